### hdl/dcla_pkg.sv
// Shared types and constants for the d-choice least-loaded bin allocator.
// No dependencies; imported by dcla_ctrl, dcla_dp and the top level.
`timescale 1ns / 1ps

package dcla_pkg;

	// fixed field widths
	localparam int IDX_W      = 9;
	localparam int COIN_W     = 16;
	localparam int OUT_LOAD_W = 24;
	localparam int BETA_W     = 17;
	localparam int BINS_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int M_TUSER_W  = 2;

	// defaults for the top-level parameters
	localparam int DEF_NUM_BINS  = 512;
	localparam int DEF_LOAD_BITS = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BINS   = 2'd2;

	// request kinds carried in s_tuser
	localparam logic CMD_CLEAR = 1'b0;
	localparam logic CMD_CAND  = 1'b1;

	// policy codes
	localparam logic POL_MIN  = 1'b0;
	localparam logic POL_BETA = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch request fields, start load read
		logic lookup;     // compare candidate, update best / ball state
		logic commit;     // increment chosen bin, load result register
		logic sweep;      // write one zero during the clearing pass
		logic clear_res;  // load clear acknowledge, drop any open ball
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic finish;     // ball closes on this candidate
		logic sweep_done; // last entry of the clearing pass
	} dp_stat_t;

endpackage

### hdl/d_choice_least_loaded_bin_allocator_top.sv
// Candidate request: accepted, then its load compared in ST_LOOK; no result unless it closes the ball.
// Closing candidate: result register loaded in ST_FIN, after ST_LOOK; increment uses the one
// write port of the load memory. One request in flight; next accepted once result is taken.
// Clear request: zeroing pass over all NUM_BINS entries of the load memory, then the acknowledge.
// Reset (arst_n low, async): control cleared, then a zeroing pass over the load memory, s_tready low.
// Config registers reset to policy 0, beta 0, bins_in_use 512.
`timescale 1ns / 1ps

module d_choice_least_loaded_bin_allocator_top #(
	parameter int NUM_BINS  = dcla_pkg::DEF_NUM_BINS,
	parameter int LOAD_BITS = dcla_pkg::DEF_LOAD_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dcla_pkg::S_TDATA_W-1:0]  s_tdata,   // bin_index[8:0], coin[24:9]
	input  logic                            s_tuser,   // command
	input  logic                            s_tlast,   // last_choice
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dcla_pkg::M_TDATA_W-1:0]  m_tdata,   // placed_bin[8:0], new_load[32:9]
	output logic [dcla_pkg::M_TUSER_W-1:0]  m_tuser,   // index_error[0], clear_done[1]
	input  logic                            cfg_we,
	input  logic [dcla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcla_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dcla_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dcla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	dcla_dp #(
		.NUM_BINS  (NUM_BINS),
		.LOAD_BITS (LOAD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// one request at a time: no accept while a result is pending
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while result pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted back-to-back requests");

	a_clear_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
		else $error("clear acknowledge carries payload");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0))
		else $error("dropped ball reports a bin");

endmodule

### hdl/dcla_ctrl.sv
// Controller FSM for the bin allocator: sequences lookup, commit and clearing.
// Depends on dcla_pkg; drives dcla_dp through dp_cmd_t.
`timescale 1ns / 1ps

module dcla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	output dcla_pkg::dp_cmd_t cmd,
	input  dcla_pkg::dp_stat_t stat
);
	import dcla_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_FIN,
		ST_SWEEP
	} state_t;

	state_t state_q;
	logic   ack_q;       // clearing pass was started by a clear request
	logic   res_valid_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && !res_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = res_valid_q;

	always_comb begin
		cmd.capture   = accept;
		cmd.lookup    = (state_q == ST_LOOK);
		cmd.commit    = (state_q == ST_FIN);
		cmd.sweep     = (state_q == ST_SWEEP);
		cmd.clear_res = (state_q == ST_SWEEP) && stat.sweep_done && ack_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;  // memory is zeroed after reset
			ack_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && m_tready)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == CMD_CLEAR) begin
							state_q <= ST_SWEEP;
							ack_q   <= 1'b1;
						end else begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					state_q <= stat.finish ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					res_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SWEEP: begin
					if (stat.sweep_done) begin
						if (ack_q)
							res_valid_q <= 1'b1;
						ack_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/dcla_dp.sv
// Datapath for the bin allocator: load memory, config registers, best-candidate
// tracking and result register. Depends on dcla_pkg; controlled by dcla_ctrl.
`timescale 1ns / 1ps

module dcla_dp #(
	parameter int NUM_BINS  = dcla_pkg::DEF_NUM_BINS,
	parameter int LOAD_BITS = dcla_pkg::DEF_LOAD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dcla_pkg::dp_cmd_t                 cmd,
	output dcla_pkg::dp_stat_t                stat,
	input  logic [dcla_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	input  logic                              cfg_we,
	input  logic [dcla_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dcla_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic [dcla_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [dcla_pkg::M_TUSER_W-1:0]    m_tuser
);
	import dcla_pkg::*;

	localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int LW = $clog2(NUM_BINS + 1);
	localparam int CW = (LW > BINS_W) ? LW : BINS_W;

	// configuration
	logic              policy_q;
	logic [BETA_W-1:0] beta_q;
	logic [BINS_W-1:0] bins_q;

	// captured request
	logic [IDX_W-1:0]  idx_q;
	logic [COIN_W-1:0] coin_q;
	logic              last_q;

	// load memory
	logic [LOAD_BITS-1:0] mem [NUM_BINS];
	logic [LOAD_BITS-1:0] rd_q;
	logic [AW-1:0]        sweep_q;

	// ball state
	logic [IDX_W-1:0]     best_bin_q;
	logic [LOAD_BITS-1:0] best_load_q;
	logic                 ball_open_q;
	logic                 ball_bad_q;
	logic                 fin_bad_q;

	// result register
	logic [IDX_W-1:0]      res_bin_q;
	logic [OUT_LOAD_W-1:0] res_load_q;
	logic                  res_err_q;
	logic                  res_clr_q;

	logic [CW-1:0]        limit;
	logic                 first;
	logic                 bad_now;
	logic                 take;
	logic                 beta_hit;
	logic                 bad_acc;
	logic [LOAD_BITS-1:0] inc;
	logic [31:0]          inc_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_MIN;
			beta_q   <= '0;
			bins_q   <= BINS_W'(512);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[0];
				REG_BETA:   beta_q   <= cfg_data[BETA_W-1:0];
				REG_BINS:   bins_q   <= cfg_data[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= s_tdata[IDX_W-1:0];
			coin_q <= s_tdata[IDX_W +: COIN_W];
			last_q <= s_tlast;
			rd_q   <= mem[AW'(s_tdata[IDX_W-1:0])];
		end
	end

	// active bin count, capped at the memory depth
	assign limit = (CW'(bins_q) >= CW'(NUM_BINS)) ? CW'(NUM_BINS) : CW'(bins_q);

	always_comb begin
		first    = !ball_open_q;
		bad_now  = (CW'(idx_q) >= limit);
		take     = !bad_now && (first ||
			((policy_q == POL_BETA) ? (rd_q <= best_load_q) : (rd_q < best_load_q)));
		beta_hit = !bad_now && first && (policy_q == POL_BETA) &&
			({1'b0, coin_q} < beta_q);
		bad_acc  = (!first && ball_bad_q) || bad_now;
		stat.finish     = beta_hit || last_q;
		stat.sweep_done = (sweep_q == AW'(NUM_BINS - 1));
		inc   = (best_load_q == '1) ? best_load_q : best_load_q + 1'b1;
		inc_w = 32'(inc);
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep)
			mem[sweep_q] <= '0;
		else if (cmd.commit && !fin_bad_q)
			mem[AW'(best_bin_q)] <= inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			best_bin_q  <= '0;
			best_load_q <= '0;
			ball_open_q <= 1'b0;
			ball_bad_q  <= 1'b0;
			fin_bad_q   <= 1'b0;
		end else begin
			if (cmd.sweep)
				sweep_q <= stat.sweep_done ? '0 : sweep_q + 1'b1;
			if (cmd.lookup) begin
				if (take) begin
					best_bin_q  <= idx_q;
					best_load_q <= rd_q;
				end
				ball_open_q <= !stat.finish;
				ball_bad_q  <= stat.finish ? 1'b0 : bad_acc;
				fin_bad_q   <= bad_acc;
			end
			if (cmd.clear_res) begin
				best_bin_q  <= '0;
				best_load_q <= '0;
				ball_open_q <= 1'b0;
				ball_bad_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_bin_q  <= fin_bad_q ? '0 : best_bin_q;
			res_load_q <= fin_bad_q ? '0 : inc_w[OUT_LOAD_W-1:0];
			res_err_q  <= fin_bad_q;
			res_clr_q  <= 1'b0;
		end else if (cmd.clear_res) begin
			res_bin_q  <= '0;
			res_load_q <= '0;
			res_err_q  <= 1'b0;
			res_clr_q  <= 1'b1;
		end
	end

	assign m_tdata = M_TDATA_W'({res_load_q, res_bin_q});
	assign m_tuser = {res_clr_q, res_err_q};

endmodule

### tb/testbench.sv
// Self-checking bench for the d-choice least-loaded bin allocator top level.
// Directed table, then randomized ball streams under several policies and flow-control mixes;
// every response is checked against an in-bench allocation predictor or a table row's expected value. Needs dcla_pkg.
`timescale 1ns / 1ps

module testbench;
	import dcla_pkg::*;

	localparam int NBINS = DEF_NUM_BINS;
	localparam int PHASE_ITEMS = 110;

	typedef struct packed {
		logic [IDX_W-1:0]      placed_bin;
		logic [OUT_LOAD_W-1:0] new_load;
		logic                  index_error;
		logic                  clear_done;
	} alloc_res_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_sel;
		logic [CFG_DATA_W-1:0] reg_val;
		logic                  cmd;
		logic [IDX_W-1:0]      idx;
		logic                  last;
		logic [COIN_W-1:0]     coin;
		logic                  typed;
		alloc_res_t            want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;   // bin_index[8:0], coin[24:9]
	logic                  s_tuser = 1'b0; // command
	logic                  s_tlast = 1'b0; // last_choice
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;        // placed_bin[8:0], new_load[32:9]
	logic [M_TUSER_W-1:0]  m_tuser;        // index_error[0], clear_done[1]
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	d_choice_least_loaded_bin_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [OUT_LOAD_W-1:0] load_tbl [NBINS];
	logic [IDX_W-1:0]      best_bin = '0;
	logic [OUT_LOAD_W-1:0] best_load = '0;
	bit                    ball_open = 0;
	bit                    ball_bad = 0;
	logic                  mode = POL_MIN;
	logic [BETA_W-1:0]     beta = '0;
	logic [BINS_W-1:0]     bins_active = 10'd512;

	alloc_res_t  pending_allocs [$];
	dir_row_t    dir_tab [$];
	int unsigned err_cnt = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned rx_hold = 0;
	int unsigned items;

	task automatic place_ball(output alloc_res_t res);
		res = '0;
		if (ball_bad) begin
			res.index_error = 1'b1;
		end else begin
			if (load_tbl[best_bin] != '1)
				load_tbl[best_bin] = load_tbl[best_bin] + 1'b1;
			res.placed_bin = best_bin;
			res.new_load = load_tbl[best_bin];
		end
		ball_open = 0;
		ball_bad = 0;
	endtask

	task automatic alloc_predict(input logic cmd, input logic [IDX_W-1:0] idx, input logic last,
			input logic [COIN_W-1:0] coin, output bit produced, output alloc_res_t res);
		int unsigned limit;
		bit first;
		logic [OUT_LOAD_W-1:0] ld;
		res = '0;
		produced = 0;
		if (cmd == CMD_CLEAR) begin
			foreach (load_tbl[i])
				load_tbl[i] = '0;
			best_bin = '0;
			best_load = '0;
			ball_open = 0;
			ball_bad = 0;
			res.clear_done = 1'b1;
			produced = 1;
			return;
		end
		limit = (bins_active > NBINS) ? NBINS : bins_active;
		first = !ball_open;
		if (first)
			ball_bad = 0;
		ball_open = 1;
		if (idx >= limit) begin
			ball_bad = 1;  // load not read for a bad index
		end else begin
			ld = load_tbl[idx];
			if (first) begin
				best_bin = idx;
				best_load = ld;
				// beta coin places the ball on the first candidate right away
				if (mode == POL_BETA && coin < beta) begin
					place_ball(res);
					produced = 1;
					return;
				end
			end else if (mode == POL_MIN ? (ld < best_load) : (ld <= best_load)) begin
				best_bin = idx;
				best_load = ld;
			end
		end
		if (last) begin
			place_ball(res);
			produced = 1;
		end
	endtask

	function automatic dir_row_t req_row(logic cmd, logic [IDX_W-1:0] idx, logic last,
			logic [COIN_W-1:0] coin);
		dir_row_t r;
		r = '0;
		r.kind = ROW_REQ;
		r.cmd = cmd;
		r.idx = idx;
		r.last = last;
		r.coin = coin;
		return r;
	endfunction

	function automatic dir_row_t chk_row(logic cmd, logic [IDX_W-1:0] idx, logic last,
			logic [COIN_W-1:0] coin, logic [IDX_W-1:0] bin, logic [OUT_LOAD_W-1:0] load,
			logic err, logic clr);
		dir_row_t r;
		r = req_row(cmd, idx, last, coin);
		r.typed = 1'b1;
		r.want = {bin, load, err, clr};
		return r;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= val;
		@(posedge clk);
		case (sel)
			REG_POLICY: mode = val[0];
			REG_BETA:   beta = val[BETA_W-1:0];
			REG_BINS:   bins_active = val[BINS_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// wait for all responses, then let a trailing candidate finish its compare
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_allocs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_req(input logic cmd, input logic [IDX_W-1:0] idx, input logic last,
			input logic [COIN_W-1:0] coin, input logic typed, input alloc_res_t want);
		bit produced;
		alloc_res_t res;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tlast <= last;
		s_tdata <= {7'b0, coin, idx};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		alloc_predict(cmd, idx, last, coin, produced, res);
		if (produced)
			pending_allocs.push_back(typed ? want : res);
	endtask

	// mostly a small hot set so loads differ and ties happen; some bad indexes
	function automatic logic [IDX_W-1:0] pick_bin();
		int unsigned lim, r;
		lim = (bins_active > NBINS) ? NBINS : bins_active;
		r = $urandom_range(99, 0);
		if (r < 8 && lim < NBINS)
			return IDX_W'($urandom_range(NBINS - 1, lim));
		if (r < 50)
			return IDX_W'($urandom_range((lim < 8 ? lim : 8) - 1, 0));
		return IDX_W'($urandom_range(lim - 1, 0));
	endfunction

	task automatic send_ball();
		int unsigned n;
		bit keep_last;
		if ($urandom_range(99, 0) < 3) begin
			send_req(CMD_CLEAR, IDX_W'($urandom), 1'($urandom), COIN_W'($urandom), 1'b0, '0);
			items++;
			return;
		end
		n = $urandom_range(4, 1);
		// a missing last mark merges this ball into the next one
		keep_last = ($urandom_range(99, 0) >= 5);
		for (int k = 0; k < n; k++)
			send_req(CMD_CAND, pick_bin(), (k == n - 1) && keep_last, COIN_W'($urandom),
				1'b0, '0);
		items += n;
	endtask

	always @(posedge clk) begin
		alloc_res_t got, want;
		if (m_tvalid === 1'b1 && m_tready) begin
			got = {m_tdata[8:0], m_tdata[32:9], m_tuser[0], m_tuser[1]};
			if (pending_allocs.size() == 0) begin
				$display("%0t: unexpected response bin=%0d load=%0d err=%b clr=%b",
					$time, got.placed_bin, got.new_load, got.index_error, got.clear_done);
				err_cnt++;
			end else begin
				want = pending_allocs.pop_front();
				if (got.placed_bin !== want.placed_bin || got.new_load !== want.new_load ||
						got.index_error !== want.index_error ||
						got.clear_done !== want.clear_done) begin
					$display({"%0t: expected bin=%0d load=%0d err=%b clr=%b, ",
						"got bin=%0d load=%0d err=%b clr=%b"},
						$time, want.placed_bin, want.new_load, want.index_error,
						want.clear_done, got.placed_bin, got.new_load, got.index_error,
						got.clear_done);
					err_cnt++;
				end
			end
		end
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= rx_stall_pct);
		end
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		bit held, paused;
		foreach (load_tbl[i])
			load_tbl[i] = '0;

		dir_tab.push_back(chk_row(CMD_CLEAR, 9'd0, 1'b0, 16'h0000, 9'd0, 24'd0, 1'b0, 1'b1));
		dir_tab.push_back(chk_row(CMD_CAND, 9'd511, 1'b1, 16'hFFFF, 9'd511, 24'd1, 1'b0, 1'b0));
		dir_tab.push_back(chk_row(CMD_CAND, 9'd0, 1'b1, 16'h0000, 9'd0, 24'd1, 1'b0, 1'b0));
		dir_tab.push_back(req_row(CMD_CAND, 9'd0, 1'b0, 16'h1234));
		dir_tab.push_back(req_row(CMD_CAND, 9'd511, 1'b0, 16'hFFFF));
		dir_tab.push_back(req_row(CMD_CAND, 9'd7, 1'b1, 16'h0000));
		// equal loads in min mode: earliest wins
		dir_tab.push_back(req_row(CMD_CAND, 9'd3, 1'b0, 16'h5555));
		dir_tab.push_back(req_row(CMD_CAND, 9'd4, 1'b1, 16'hAAAA));
		dir_tab.push_back(cfg_row(REG_BINS, 17'd1));
		dir_tab.push_back(chk_row(CMD_CAND, 9'd1, 1'b1, 16'h0000, 9'd0, 24'd0, 1'b1, 1'b0));
		dir_tab.push_back(req_row(CMD_CAND, 9'd0, 1'b0, 16'h0000));
		dir_tab.push_back(req_row(CMD_CAND, 9'd300, 1'b0, 16'h0000));
		dir_tab.push_back(chk_row(CMD_CAND, 9'd0, 1'b1, 16'h0000, 9'd0, 24'd0, 1'b1, 1'b0));
		dir_tab.push_back(req_row(CMD_CAND, 9'd0, 1'b1, 16'hFFFF));
		dir_tab.push_back(cfg_row(REG_BINS, 17'd512));
		dir_tab.push_back(cfg_row(REG_POLICY, 17'(POL_BETA)));
		dir_tab.push_back(cfg_row(REG_BETA, 17'd65536));
		// every coin is below full beta: placed on the first candidate
		dir_tab.push_back(req_row(CMD_CAND, 9'd9, 1'b0, 16'hFFFF));
		dir_tab.push_back(req_row(CMD_CAND, 9'd10, 1'b1, 16'h0000));
		dir_tab.push_back(cfg_row(REG_BETA, 17'd0));
		// equal loads in beta mode: later wins
		dir_tab.push_back(req_row(CMD_CAND, 9'd3, 1'b0, 16'h0000));
		dir_tab.push_back(req_row(CMD_CAND, 9'd9, 1'b1, 16'h0000));
		dir_tab.push_back(cfg_row(REG_BETA, 17'd32768));
		dir_tab.push_back(req_row(CMD_CAND, 9'd20, 1'b0, 16'h7FFF));
		dir_tab.push_back(req_row(CMD_CAND, 9'd21, 1'b0, 16'h8000));
		dir_tab.push_back(req_row(CMD_CAND, 9'd22, 1'b1, 16'h0001));
		// clear abandons the open ball
		dir_tab.push_back(req_row(CMD_CAND, 9'd0, 1'b0, 16'hFFFF));
		dir_tab.push_back(chk_row(CMD_CLEAR, 9'd0, 1'b0, 16'h0000, 9'd0, 24'd0, 1'b0, 1'b1));
		dir_tab.push_back(req_row(CMD_CAND, 9'd5, 1'b1, 16'hFFFF));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				drain();
				write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
			end else begin
				send_req(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].last, dir_tab[i].coin,
					dir_tab[i].typed, dir_tab[i].want);
			end
		end

		held = 0;
		paused = 0;
		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: begin write_reg(REG_POLICY, 17'(POL_MIN));  write_reg(REG_BETA, 17'd0);
					write_reg(REG_BINS, 17'd512); end
				1: begin write_reg(REG_POLICY, 17'(POL_MIN));
					write_reg(REG_BETA, 17'($urandom_range(65536, 0)));
					write_reg(REG_BINS, 17'd16); end
				2: begin write_reg(REG_POLICY, 17'(POL_BETA)); write_reg(REG_BETA, 17'd65536);
					write_reg(REG_BINS, 17'd512); end
				3: begin write_reg(REG_POLICY, 17'(POL_BETA)); write_reg(REG_BETA, 17'd0);
					write_reg(REG_BINS, 17'd1); end
				4: begin write_reg(REG_POLICY, 17'(POL_BETA));
					write_reg(REG_BETA, 17'($urandom_range(65536, 0)));
					write_reg(REG_BINS, 17'($urandom_range(64, 2))); end
				5: begin write_reg(REG_POLICY, 17'(POL_MIN));  write_reg(REG_BETA, 17'd65536);
					write_reg(REG_BINS, 17'd2); end
				6: begin write_reg(REG_POLICY, 17'(POL_BETA));
					write_reg(REG_BETA, 17'($urandom_range(65536, 0)));
					write_reg(REG_BINS, 17'd512); end
				default: begin write_reg(REG_POLICY, 17'(POL_BETA));
					write_reg(REG_BETA, 17'd32768);
					write_reg(REG_BINS, 17'($urandom_range(512, 1))); end
			endcase
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			items = 0;
			while (items < PHASE_ITEMS) begin
				// long sink hold-off while requests keep coming: backpressure reaches s_tready
				if (p == 2 && !held && items >= 40) begin
					tx_idle_pct = 0;
					rx_hold = 400;
					held = 1;
				end
				if (p == 4 && !paused && items >= 50) begin
					drain();
					paused = 1;
				end
				send_ball();
			end
			if (ball_open)
				send_req(CMD_CAND, 9'd0, 1'b1, COIN_W'($urandom), 1'b0, '0);
		end

		drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
